// ----- rtl/speck_block_cipher_assert.svh -----
// Assertion macros used by the Speck cipher top level.
// No dependencies.
`ifndef SPECK_BLOCK_CIPHER_ASSERT_SVH
`define SPECK_BLOCK_CIPHER_ASSERT_SVH

`define SPK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define SPK_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ----- rtl/spk_pkg.sv -----
// Speck package: variant tables, masks and rotations.
// No dependencies.
package spk_pkg;

  localparam int unsigned WordW      = 64;
  localparam int unsigned VarW       = 4;
  localparam int unsigned NumVar     = 10;
  localparam int unsigned DefRounds  = 34;
  localparam int unsigned RoundCntW  = 6;

  localparam logic [2:0] RegVariant = 3'd0;
  localparam logic [2:0] RegKey0    = 3'd1;
  localparam logic [2:0] RegKey3    = 3'd4;

  function automatic logic [6:0] word_bits(input logic [VarW-1:0] v);
    unique case (v)
      4'd0:             word_bits = 7'd16;
      4'd1, 4'd2:       word_bits = 7'd24;
      4'd3, 4'd4:       word_bits = 7'd32;
      4'd5, 4'd6:       word_bits = 7'd48;
      default:          word_bits = 7'd64;
    endcase
  endfunction

  function automatic logic [2:0] key_words(input logic [VarW-1:0] v);
    unique case (v)
      4'd1, 4'd3, 4'd6, 4'd8: key_words = 3'd3;
      4'd5, 4'd7:             key_words = 3'd2;
      default:                key_words = 3'd4;
    endcase
  endfunction

  function automatic logic [RoundCntW-1:0] round_count(input logic [VarW-1:0] v);
    unique case (v)
      4'd0, 4'd1: round_count = 6'd22;
      4'd2:       round_count = 6'd23;
      4'd3:       round_count = 6'd26;
      4'd4:       round_count = 6'd27;
      4'd5:       round_count = 6'd28;
      4'd6:       round_count = 6'd29;
      4'd7:       round_count = 6'd32;
      4'd8:       round_count = 6'd33;
      default:    round_count = 6'd34;
    endcase
  endfunction

  function automatic logic [WordW-1:0] word_mask(input logic [VarW-1:0] v);
    unique case (word_bits(v))
      7'd16:   word_mask = 64'h0000_0000_0000_FFFF;
      7'd24:   word_mask = 64'h0000_0000_00FF_FFFF;
      7'd32:   word_mask = 64'h0000_0000_FFFF_FFFF;
      7'd48:   word_mask = 64'h0000_FFFF_FFFF_FFFF;
      default: word_mask = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  // rotate right by a (7 for 16-bit words, else 8) within word size
  function automatic logic [WordW-1:0] rot_a_r(input logic [WordW-1:0] x,
                                              input logic [VarW-1:0] v);
    unique case (word_bits(v))
      7'd16:   rot_a_r = {48'd0, x[6:0], x[15:7]};
      7'd24:   rot_a_r = {40'd0, x[7:0], x[23:8]};
      7'd32:   rot_a_r = {32'd0, x[7:0], x[31:8]};
      7'd48:   rot_a_r = {16'd0, x[7:0], x[47:8]};
      default: rot_a_r = {x[7:0], x[63:8]};
    endcase
  endfunction

  function automatic logic [WordW-1:0] rot_a_l(input logic [WordW-1:0] x,
                                              input logic [VarW-1:0] v);
    unique case (word_bits(v))
      7'd16:   rot_a_l = {48'd0, x[8:0], x[15:9]};
      7'd24:   rot_a_l = {40'd0, x[15:0], x[23:16]};
      7'd32:   rot_a_l = {32'd0, x[23:0], x[31:24]};
      7'd48:   rot_a_l = {16'd0, x[39:0], x[47:40]};
      default: rot_a_l = {x[55:0], x[63:56]};
    endcase
  endfunction

  function automatic logic [WordW-1:0] rot_b_l(input logic [WordW-1:0] x,
                                              input logic [VarW-1:0] v);
    unique case (word_bits(v))
      7'd16:   rot_b_l = {48'd0, x[13:0], x[15:14]};
      7'd24:   rot_b_l = {40'd0, x[20:0], x[23:21]};
      7'd32:   rot_b_l = {32'd0, x[28:0], x[31:29]};
      7'd48:   rot_b_l = {16'd0, x[44:0], x[47:45]};
      default: rot_b_l = {x[60:0], x[63:61]};
    endcase
  endfunction

  function automatic logic [WordW-1:0] rot_b_r(input logic [WordW-1:0] x,
                                              input logic [VarW-1:0] v);
    unique case (word_bits(v))
      7'd16:   rot_b_r = {48'd0, x[1:0], x[15:2]};
      7'd24:   rot_b_r = {40'd0, x[2:0], x[23:3]};
      7'd32:   rot_b_r = {32'd0, x[2:0], x[31:3]};
      7'd48:   rot_b_r = {16'd0, x[2:0], x[47:3]};
      default: rot_b_r = {x[2:0], x[63:3]};
    endcase
  endfunction

  typedef struct packed {
    logic              go;
    logic              dec;
    logic [VarW-1:0]   variant;
  } spk_ctl_t;

endpackage

// ----- rtl/spk_key_cell.sv -----
// One cell of the round-key line: holds one round key and hands it on.
// Depends on spk_pkg.
module spk_key_cell
  import spk_pkg::*;
(
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic             dir_i,
  input  logic [WordW-1:0] prev_i,
  input  logic [WordW-1:0] next_i,
  output logic [WordW-1:0] key_o
);

  logic [WordW-1:0] key_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q <= dir_i ? next_i : prev_i;
    end
  end

  assign key_o = key_q;

endmodule

// ----- rtl/spk_round.sv -----
// Shared Speck round unit: one encrypt or decrypt round, and the key step.
// Depends on spk_pkg.
module spk_round
  import spk_pkg::*;
(
  input  logic [VarW-1:0]  variant_i,
  input  logic             dec_i,
  input  logic [WordW-1:0] x_i,
  input  logic [WordW-1:0] y_i,
  input  logic [WordW-1:0] k_i,
  output logic [WordW-1:0] x_o,
  output logic [WordW-1:0] y_o
);

  logic [WordW-1:0] m;
  logic [WordW-1:0] ex;
  logic [WordW-1:0] dy;

  always_comb begin
    m  = word_mask(variant_i);
    ex = ((rot_a_r(x_i, variant_i) + y_i) & m) ^ k_i;
    dy = rot_b_r(x_i ^ y_i, variant_i);
    if (dec_i) begin
      y_o = dy;
      x_o = rot_a_l(((x_i ^ k_i) - dy) & m, variant_i);
    end else begin
      x_o = ex;
      y_o = rot_b_l(y_i, variant_i) ^ ex;
    end
  end

endmodule

// ----- rtl/speck_block_cipher.sv -----
// Speck block cipher top level: config registers, key expansion, round engine.
// Depends on spk_pkg, spk_key_cell, spk_round and speck_block_cipher_assert.svh.
//
// channel | direction | payload
// cfg     | in        | cfg_index_i, cfg_data_i
// in      | in        | mode_i, block_high_i, block_low_i
// out     | out       | result_high_o, result_low_o
//
// A request is taken only when idle; a single round unit is then iterated once per
// round (22..34 rounds) while the round keys circulate through a ring of key cells, one
// shift per round, and the StDone state then hands the block to the output register.
// A new request is taken only after the result has been handed over. The hand-over
// waits while an earlier result is still unread. After reset and after each config
// write the schedule is re-expanded; no request is taken meanwhile. A pending config
// request holds off a block request.
`include "speck_block_cipher_assert.svh"

module speck_block_cipher
  import spk_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = DefRounds
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [WordW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             mode_i,
  input  logic [WordW-1:0] block_high_i,
  input  logic [WordW-1:0] block_low_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] result_high_o,
  output logic [WordW-1:0] result_low_o
);

  localparam int unsigned CntW = $clog2(MAX_ROUNDS + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExp  = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [VarW-1:0]  variant_q, variant_d;
  logic [WordW-1:0] key_q [4];
  logic [WordW-1:0] key_d [4];
  logic [CntW-1:0]  cnt_q, cnt_d, nrounds;
  logic             dec_q;
  logic [WordW-1:0] x_q, y_q, rx, ry, mask, mask_d;
  logic [WordW-1:0] l_q [3];
  logic [WordW-1:0] kcell [MAX_ROUNDS];
  logic [WordW-1:0] head_k, ins_k;
  logic             shift, dir;
  logic             out_valid_q;
  logic [WordW-1:0] res_h_q, res_l_q;
  logic [WordW-1:0] exp_k_q, nl, exp_next;
  logic             cfg_fire, in_fire;
  logic [RoundCntW-1:0] rc;

  assign rc      = round_count(variant_q);
  assign nrounds = (int'(rc) > MAX_ROUNDS) ? CntW'(MAX_ROUNDS) : CntW'(rc);
  assign mask    = word_mask(variant_q);

  assign cfg_ready_o = (state_q == StIdle);
  assign in_ready_o  = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;

  // register values as they stand after this edge, so expansion sees a fresh write
  always_comb begin
    variant_d = variant_q;
    for (int i = 0; i < 4; i++) key_d[i] = key_q[i];
    if (cfg_fire) begin
      if (cfg_index_i == RegVariant) begin
        if (cfg_data_i[VarW-1:0] < VarW'(NumVar)) variant_d = cfg_data_i[VarW-1:0];
      end else if (cfg_index_i >= RegKey0 && cfg_index_i <= RegKey3) begin
        key_d[2'(cfg_index_i - RegKey0)] = cfg_data_i;
      end
    end
  end

  assign mask_d = word_mask(variant_d);

  // Key ring: cell 0 holds the current round key. Encrypt and expansion rotate
  // towards cell 0; decrypt rotates the other way. The ring holds nrounds keys
  // as a window, kept aligned by always doing full turns of nrounds shifts.
  // Rotation must wrap at nrounds, so the wrap point is selected per variant.
  assign head_k = kcell[0];

  always_comb begin
    ins_k = kcell[0];
    for (int i = 0; i < MAX_ROUNDS; i++) begin
      if (CntW'(i) == nrounds - 1'b1) ins_k = kcell[i];
    end
  end

  // Expansion: round i produces key i+1 from key i held in exp_k_q.
  spk_round u_kstep (
    .variant_i (variant_q),
    .dec_i     (1'b0),
    .x_i       (l_q[0]),
    .y_i       (exp_k_q),
    .k_i       ((WordW'(cnt_q)) & mask),
    .x_o       (nl),
    .y_o       (exp_next)
  );

  spk_round u_round (
    .variant_i (variant_q),
    .dec_i     (dec_q),
    .x_i       (x_q),
    .y_i       (y_q),
    .k_i       (dec_q ? ins_k : head_k),
    .x_o       (rx),
    .y_o       (ry)
  );

  assign shift = (state_q == StExp) || (state_q == StRun);
  assign dir   = (state_q == StRun) && dec_q;

  for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_cell
    localparam int Up = (g == MAX_ROUNDS - 1) ? 0 : g + 1;
    localparam int Dn = (g == 0) ? 0 : g - 1;
    logic [WordW-1:0] from_prev, from_next;
    always_comb begin
      // encrypt/expand direction: cell g takes cell g+1 (wrap at nrounds-1)
      from_prev = kcell[Up];
      if (CntW'(g) == nrounds - 1'b1) begin
        from_prev = (state_q == StExp) ? exp_k_q : kcell[0];
      end
      from_next = (g == 0) ? ins_k : kcell[Dn];
    end
    spk_key_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .dir_i   (dir),
      .prev_i  (from_prev),
      .next_i  (from_next),
      .key_o   (kcell[g])
    );
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (cfg_fire) begin
          state_d = StExp;
          cnt_d   = '0;
        end else if (in_fire) begin
          state_d = StRun;
          cnt_d   = '0;
        end
      end
      StExp: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == nrounds - 1'b1) state_d = StIdle;
      end
      StRun: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == nrounds - 1'b1) state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // exp_k_q walks the schedule: key i during step i
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StExp;
      cnt_q     <= '0;
      variant_q <= '0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      dec_q     <= 1'b0;
      out_valid_q <= 1'b0;
      exp_k_q   <= '0;
      for (int i = 0; i < 3; i++) l_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      variant_q <= variant_d;
      for (int i = 0; i < 4; i++) key_q[i] <= key_d[i];
      if (in_fire) begin
        dec_q <= mode_i;
      end
      if (state_q == StExp) begin
        exp_k_q <= exp_next;
        unique case (key_words(variant_q))
          3'd2: begin
            l_q[0] <= nl;
          end
          3'd3: begin
            l_q[0] <= l_q[1];
            l_q[1] <= nl;
          end
          default: begin
            l_q[0] <= l_q[1];
            l_q[1] <= l_q[2];
            l_q[2] <= nl;
          end
        endcase
      end else begin
        exp_k_q <= key_d[0] & mask_d;
        l_q[0]  <= key_d[1] & mask_d;
        l_q[1]  <= key_d[2] & mask_d;
        l_q[2]  <= key_d[3] & mask_d;
      end
      if (state_q == StDone && state_d == StIdle) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= block_high_i & mask;
      y_q <= block_low_i & mask;
    end else if (state_q == StRun) begin
      x_q <= rx;
      y_q <= ry;
    end
    if (state_q == StDone && state_d == StIdle) begin
      res_h_q <= x_q;
      res_l_q <= y_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_high_o = res_h_q;
  assign result_low_o  = res_l_q;

  `SPK_NEVER(a_no_req_busy, in_fire && state_q != StIdle, "request taken while busy")
  `SPK_ASSERT(a_cnt_bound, state_q == StRun |-> cnt_q < nrounds, "round count overrun")
  `SPK_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

endmodule

// ----- tb/speck_tb_pkg.sv -----
// Shared testbench codes for the Speck cipher checker and its test top.
// Depends on nothing.
package speck_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {ModeEncrypt = 1'b0, ModeDecrypt = 1'b1} cipher_mode_e;

  localparam logic [2:0] RegUnused = 3'd5;
  localparam int unsigned RoundLimit = 34;
endpackage

// ----- tb/speck_block_cipher_check.sv -----
// Checker for speck_block_cipher: tracks config writes, predicts each block
// and compares results in order. Depends on spk_pkg and speck_tb_pkg.
module speck_block_cipher_check
  import spk_pkg::*;
  import speck_tb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [WordW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             mode_i,
  input  logic [WordW-1:0] block_high_i,
  input  logic [WordW-1:0] block_low_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [WordW-1:0] result_high_i,
  input  logic [WordW-1:0] result_low_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ExpDepth = 8;

  typedef struct packed {
    logic [WordW-1:0] hi;
    logic [WordW-1:0] lo;
  } cipher_block_t;

  logic [3:0]       cur_variant;
  logic [WordW-1:0] key_reg [4];
  logic [WordW-1:0] sched_keys [RoundLimit];
  cipher_block_t    expected_blocks [ExpDepth];
  logic [2:0]       exp_wr, exp_rd;
  int               exp_count;

  assign pending_o = exp_count;

  function automatic int nbits(input logic [3:0] v);
    case (v)
      4'd0: return 16;
      4'd1, 4'd2: return 24;
      4'd3, 4'd4: return 32;
      4'd5, 4'd6: return 48;
      default: return 64;
    endcase
  endfunction

  function automatic int nkey_words(input logic [3:0] v);
    case (v)
      4'd1, 4'd3, 4'd6, 4'd8: return 3;
      4'd5, 4'd7: return 2;
      default: return 4;
    endcase
  endfunction

  function automatic int nrounds(input logic [3:0] v);
    int r;
    case (v)
      4'd0, 4'd1: r = 22;
      4'd2: r = 23;
      4'd3: r = 26;
      4'd4: r = 27;
      4'd5: r = 28;
      4'd6: r = 29;
      4'd7: r = 32;
      4'd8: r = 33;
      default: r = 34;
    endcase
    return r > RoundLimit ? RoundLimit : r;
  endfunction

  function automatic logic [63:0] wmask(input int n);
    return n >= 64 ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic logic [63:0] rotl_w(input logic [63:0] v, input int s, input int n);
    logic [63:0] m;
    m = wmask(n);
    v &= m;
    return ((v << s) | (v >> (n - s))) & m;
  endfunction

  function automatic logic [63:0] rotr_w(input logic [63:0] v, input int s, input int n);
    logic [63:0] m;
    m = wmask(n);
    v &= m;
    return ((v >> s) | (v << (n - s))) & m;
  endfunction

  function automatic void expand_schedule();
    logic [63:0] lw [RoundLimit + 3];
    logic [63:0] m;
    logic [63:0] nl;
    int n, kw, t, ra, rb;
    n  = nbits(cur_variant);
    m  = wmask(n);
    kw = nkey_words(cur_variant);
    t  = nrounds(cur_variant);
    ra = cur_variant == 4'd0 ? 7 : 8;
    rb = cur_variant == 4'd0 ? 2 : 3;
    for (int i = 0; i < 3; i++) lw[i] = key_reg[(i + 1) % 4] & m;
    sched_keys[0] = key_reg[0] & m;
    for (int i = 0; i + 1 < t; i++) begin
      nl = ((rotr_w(lw[i], ra, n) + sched_keys[i]) & m) ^ (64'(i) & m);
      lw[i + kw - 1] = nl;
      sched_keys[i + 1] = rotl_w(sched_keys[i], rb, n) ^ nl;
    end
  endfunction

  function automatic cipher_block_t speck_transform(input logic dec, input logic [63:0] hi,
                                                    input logic [63:0] lo);
    cipher_block_t r;
    logic [63:0] m, x, y;
    int n, t, ra, rb;
    n  = nbits(cur_variant);
    m  = wmask(n);
    t  = nrounds(cur_variant);
    ra = cur_variant == 4'd0 ? 7 : 8;
    rb = cur_variant == 4'd0 ? 2 : 3;
    x  = hi & m;
    y  = lo & m;
    if (dec == ModeEncrypt) begin
      for (int i = 0; i < t; i++) begin
        x = ((rotr_w(x, ra, n) + y) & m) ^ sched_keys[i];
        y = rotl_w(y, rb, n) ^ x;
      end
    end else begin
      for (int i = t; i > 0; i--) begin
        y = rotr_w(x ^ y, rb, n);
        x = rotl_w(((x ^ sched_keys[i - 1]) - y) & m, ra, n);
      end
    end
    r.hi = x & m;
    r.lo = y & m;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_block_t want;
    if (!rst_ni) begin
      cur_variant = '0;
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      for (int i = 0; i < RoundLimit; i++) sched_keys[i] = '0;
      expand_schedule();
      exp_wr = '0;
      exp_rd = '0;
      exp_count = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (exp_count == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result %h %h", result_high_i, result_low_i);
        end else begin
          want = expected_blocks[exp_rd];
          exp_rd++;
          exp_count--;
          if (want.hi !== result_high_i || want.lo !== result_low_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("result mismatch: expected %h %h, got %h %h",
                       want.hi, want.lo, result_high_i, result_low_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegVariant) begin
          if (cfg_data_i[3:0] <= 4'd9) cur_variant = cfg_data_i[3:0];
          expand_schedule();
        end else if (cfg_index_i >= RegKey0 && cfg_index_i <= RegKey3) begin
          key_reg[2'(cfg_index_i - RegKey0)] = cfg_data_i;
          expand_schedule();
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_blocks[exp_wr] = speck_transform(mode_i, block_high_i, block_low_i);
        exp_wr++;
        exp_count++;
      end
    end
  end
endmodule

// ----- tb/speck_block_cipher_test.sv -----
// Test top for speck_block_cipher: clock, reset, config phases, block requests
// with bursty traffic and a stalling receiver. Depends on the checker, the DUT, spk_pkg and speck_tb_pkg.
module speck_block_cipher_test;
  import spk_pkg::*;
  import speck_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 3000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [2:0]       cfg_index_i = '0;
  logic [WordW-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             mode_i = 1'b0;
  logic [WordW-1:0] block_high_i = '0;
  logic [WordW-1:0] block_low_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [WordW-1:0] result_high_o;
  logic [WordW-1:0] result_low_o;
  int               fail_count;
  int               pending;
  bit               hold_request = 1'b0;
  int               burst_left = 0;
  int               idle_cycles = 0;
  logic [WordW-1:0] last_hi = '0, last_lo = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  speck_block_cipher dut (.*);

  speck_block_cipher_check checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .block_high_i, .block_low_i,
    .out_valid_i(out_valid_o), .out_ready_i, .result_high_i(result_high_o),
    .result_low_i(result_low_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stall pattern, quiet stretches, one long hold-off on request
  initial begin
    int stall_pct;
    int run_left;
    stall_pct = 30;
    run_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_request = 1'b0;
      end
      if (run_left == 0) begin
        run_left = $urandom_range(200, 20);
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 80;
        endcase
      end
      run_left--;
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_accept(input logic which);
    logic rdy;
    forever begin
      @(negedge clk_i);
      rdy = which ? in_ready_o : cfg_ready_o;
      @(posedge clk_i);
      if (rdy) break;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    wait_accept(1'b0);
  endtask

  task automatic drain_then_settle();
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_block(input cipher_mode_e m, input logic [63:0] hi,
                            input logic [63:0] lo, input bit bursty);
    int gap;
    if (bursty && burst_left == 0) begin
      gap = $urandom_range(10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(24, 1);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    block_high_i <= hi;
    block_low_i  <= lo;
    wait_accept(1'b1);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] key_pick(input int sel);
    case (sel)
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  initial begin
    logic [3:0] variants [14];
    int phase_items;
    cipher_mode_e m;
    variants = '{4'd0, 4'd9, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8,
                 4'd0, 4'd7, 4'd9, 4'd3};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state: zero key, smallest variant, extreme blocks and one patterned block
    send_block(ModeEncrypt, '0, '0, 1'b0);
    send_block(ModeDecrypt, '0, '0, 1'b0);
    send_block(ModeEncrypt, '1, '1, 1'b0);
    send_block(ModeDecrypt, '1, '1, 1'b0);
    send_block(ModeEncrypt, 64'h6574_694c, 64'hFFFF_0000_0000_0001, 1'b0);
    in_valid_i <= 1'b0;
    drain_then_settle();

    for (int p = 0; p < 14; p++) begin
      write_reg(RegVariant, {60'd0, variants[p]});
      for (int k = 0; k < 4; k++)
        write_reg(RegKey0 + 3'(k), key_pick(p < 2 ? p : $urandom_range(5)));
      if (p == 3) write_reg(RegVariant, 64'd12);
      if (p == 5) write_reg(RegVariant, 64'hFFFF_FFFF_FFFF_FFF3);
      if (p == 7) write_reg(RegUnused + 3'($urandom_range(2)), rand64());
      cfg_valid_i <= 1'b0;
      send_block(ModeEncrypt, '1, '0, 1'b0);
      send_block(ModeDecrypt, '0, '1, 1'b0);
      phase_items = (p == 6) ? 250 : 129;
      for (int i = 0; i < phase_items; i++) begin
        if (p == 6 && i == 20) hold_request = 1'b1;
        m = cipher_mode_e'($urandom_range(1));
        if ($urandom_range(3) == 0)
          send_block(m, last_hi, last_lo, 1'b1);
        else
          send_block(m, rand64(), rand64(), 1'b1);
        last_hi = result_high_o;
        last_lo = result_low_o;
      end
      in_valid_i <= 1'b0;
      drain_then_settle();
    end

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

// ----- speck_block_cipher.f -----
+incdir+rtl
rtl/spk_pkg.sv
rtl/spk_key_cell.sv
rtl/spk_round.sv
rtl/speck_block_cipher.sv
tb/speck_tb_pkg.sv
tb/speck_block_cipher_check.sv
tb/speck_block_cipher_test.sv
